### hdl/ghp_pkg.sv
// shared codes, item record and constants for the gzip header parser
package ghp_pkg;

  // parse phases, also the byte class codes on the output
  localparam logic [2:0] PH_FIXED   = 3'd0;
  localparam logic [2:0] PH_XLEN    = 3'd1;
  localparam logic [2:0] PH_EXTRA   = 3'd2;
  localparam logic [2:0] PH_NAME    = 3'd3;
  localparam logic [2:0] PH_COMMENT = 3'd4;
  localparam logic [2:0] PH_HCRC    = 3'd5;
  localparam logic [2:0] PH_PAYLOAD = 3'd6;
  localparam logic [2:0] PH_ERROR   = 3'd7;

  // error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_ID     = 2'd1;
  localparam logic [1:0] ERR_METHOD = 2'd2;
  localparam logic [1:0] ERR_CRC    = 2'd3;

  // configuration register indexes
  localparam logic CFG_HCRC_EN   = 1'b0;
  localparam logic CFG_METHOD_EN = 1'b1;

  // header constants
  localparam logic [7:0] GZ_ID1     = 8'h1f;
  localparam logic [7:0] GZ_ID2     = 8'h8b;
  localparam logic [7:0] GZ_DEFLATE = 8'd8;
  localparam logic [3:0] FIXED_LAST = 4'd9;

  // flag byte bit positions
  localparam int FLG_TEXT    = 0;
  localparam int FLG_HCRC    = 1;
  localparam int FLG_EXTRA   = 2;
  localparam int FLG_NAME    = 3;
  localparam int FLG_COMMENT = 4;

  localparam logic [31:0] CRC32_POLY = 32'hEDB88320;

  // default depth of the queue between front and back
  localparam int FIFO_DEPTH = 4;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] cls;
    logic       last;
    logic       done;
    logic       start;
    logic [1:0] err;
    logic       text_wr;
    logic       text_val;
  } ghp_item_t;

  localparam int ITEM_W = $bits(ghp_item_t);

endpackage

### hdl/ghp_front.sv
// front end: header phase tracking, byte classification and header crc
module ghp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 in_start,
  input  logic                 hcrc_en,
  input  logic                 method_en,
  input  logic                 full,
  output logic                 push,
  output ghp_pkg::ghp_item_t   item
);

  logic [2:0]  phase, phase_next;
  logic [3:0]  cnt, cnt_next;
  logic [7:0]  flags, flags_next;
  logic [15:0] extra, extra_next;
  logic [31:0] crc, crc_next;
  logic [7:0]  hcrc_lo, hcrc_lo_next;

  logic [2:0]  phase_cur;
  logic [3:0]  cnt_cur;
  logic [7:0]  flags_cur;
  logic [15:0] extra_cur;
  logic [31:0] crc_cur;
  logic [7:0]  hcrc_lo_cur;
  logic [15:0] xlen_full;
  logic [15:0] extra_dec;
  logic        last, done, text_wr;
  logic [1:0]  err;

  // byte-wide crc32 update, reflected polynomial
  function automatic logic [31:0] crc32_step(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc_in ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ ghp_pkg::CRC32_POLY) : (c >> 1);
    end
    return ~c;
  endfunction

  // first optional field present after a phase, else payload
  function automatic logic [2:0] next_phase(input logic [2:0] after, input logic [7:0] f);
    logic [2:0] r;
    r = ghp_pkg::PH_PAYLOAD;
    if (after < ghp_pkg::PH_HCRC && f[ghp_pkg::FLG_HCRC]) r = ghp_pkg::PH_HCRC;
    if (after < ghp_pkg::PH_COMMENT && f[ghp_pkg::FLG_COMMENT]) r = ghp_pkg::PH_COMMENT;
    if (after < ghp_pkg::PH_NAME && f[ghp_pkg::FLG_NAME]) r = ghp_pkg::PH_NAME;
    if (after < ghp_pkg::PH_XLEN && f[ghp_pkg::FLG_EXTRA]) r = ghp_pkg::PH_XLEN;
    return r;
  endfunction

  assign in_ready = !full;
  assign push     = in_valid && !full;

  // start of stream clears the state seen by this beat
  always_comb begin
    phase_cur   = in_start ? ghp_pkg::PH_FIXED : phase;
    cnt_cur     = in_start ? 4'd0 : cnt;
    flags_cur   = in_start ? 8'd0 : flags;
    extra_cur   = in_start ? 16'd0 : extra;
    crc_cur     = in_start ? 32'd0 : crc;
    hcrc_lo_cur = in_start ? 8'd0 : hcrc_lo;
  end

  assign xlen_full = {in_byte, extra_cur[7:0]};
  assign extra_dec = extra_cur - 16'd1;

  // phase machine
  always_comb begin
    phase_next   = phase_cur;
    cnt_next     = cnt_cur;
    flags_next   = flags_cur;
    extra_next   = extra_cur;
    hcrc_lo_next = hcrc_lo_cur;
    crc_next     = (phase_cur < ghp_pkg::PH_HCRC) ? crc32_step(crc_cur, in_byte) : crc_cur;
    last         = 1'b0;
    done         = 1'b0;
    text_wr      = 1'b0;
    err          = ghp_pkg::ERR_NONE;
    case (phase_cur)
      ghp_pkg::PH_FIXED: begin
        if ((cnt_cur == 4'd0 && in_byte != ghp_pkg::GZ_ID1) ||
            (cnt_cur == 4'd1 && in_byte != ghp_pkg::GZ_ID2)) begin
          err        = ghp_pkg::ERR_ID;
          phase_next = ghp_pkg::PH_ERROR;
        end else begin
          if (cnt_cur == 4'd2 && method_en && in_byte != ghp_pkg::GZ_DEFLATE) begin
            err        = ghp_pkg::ERR_METHOD;
            phase_next = ghp_pkg::PH_ERROR;
          end
          if (cnt_cur == 4'd3) begin
            flags_next = in_byte;
            text_wr    = 1'b1;
          end
          if (cnt_cur >= ghp_pkg::FIXED_LAST) begin
            last       = 1'b1;
            cnt_next   = 4'd0;
            phase_next = next_phase(ghp_pkg::PH_FIXED, flags_cur);
            done       = (phase_next == ghp_pkg::PH_PAYLOAD);
          end else begin
            cnt_next = cnt_cur + 4'd1;
          end
        end
      end
      ghp_pkg::PH_XLEN: begin
        if (cnt_cur == 4'd0) begin
          extra_next = {8'h00, in_byte};
          cnt_next   = 4'd1;
        end else begin
          extra_next = xlen_full;
          cnt_next   = 4'd0;
          last       = 1'b1;
          if (xlen_full != 16'd0) begin
            phase_next = ghp_pkg::PH_EXTRA;
          end else begin
            phase_next = next_phase(ghp_pkg::PH_EXTRA, flags_cur);
            done       = (phase_next == ghp_pkg::PH_PAYLOAD);
          end
        end
      end
      ghp_pkg::PH_EXTRA: begin
        extra_next = extra_dec;
        if (extra_dec == 16'd0) begin
          last       = 1'b1;
          phase_next = next_phase(ghp_pkg::PH_EXTRA, flags_cur);
          done       = (phase_next == ghp_pkg::PH_PAYLOAD);
        end
      end
      ghp_pkg::PH_NAME, ghp_pkg::PH_COMMENT: begin
        if (in_byte == 8'd0) begin
          last       = 1'b1;
          phase_next = next_phase(phase_cur, flags_cur);
          done       = (phase_next == ghp_pkg::PH_PAYLOAD);
        end
      end
      ghp_pkg::PH_HCRC: begin
        if (cnt_cur == 4'd0) begin
          hcrc_lo_next = in_byte;
          cnt_next     = 4'd1;
        end else begin
          cnt_next   = 4'd0;
          last       = 1'b1;
          done       = 1'b1;
          phase_next = ghp_pkg::PH_PAYLOAD;
          if (hcrc_en && {in_byte, hcrc_lo_cur} != crc_cur[15:0]) begin
            err        = ghp_pkg::ERR_CRC;
            phase_next = ghp_pkg::PH_ERROR;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // record for the back end
  always_comb begin
    item.data     = in_byte;
    item.cls      = phase_cur;
    item.last     = last;
    item.done     = done;
    item.start    = in_start;
    item.err      = err;
    item.text_wr  = text_wr;
    item.text_val = in_byte[ghp_pkg::FLG_TEXT];
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= ghp_pkg::PH_FIXED;
      cnt     <= 4'd0;
      flags   <= 8'd0;
      extra   <= 16'd0;
      crc     <= 32'd0;
      hcrc_lo <= 8'd0;
    end else if (push) begin
      phase   <= phase_next;
      cnt     <= cnt_next;
      flags   <= flags_next;
      extra   <= extra_next;
      crc     <= crc_next;
      hcrc_lo <= hcrc_lo_next;
    end
  end

endmodule

### hdl/ghp_fifo.sv
// short queue of classified bytes between front and back
module ghp_fifo #(
  parameter int Depth = ghp_pkg::FIFO_DEPTH,
  parameter int Width = ghp_pkg::ITEM_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [Width-1:0] wr_data,
  input  logic             rd_en,
  output logic [Width-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem [Depth];
  logic [AddrW-1:0] wr_ptr, rd_ptr;
  logic [AddrW:0]   count;

  assign full    = (count == (AddrW+1)'(Depth));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AddrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AddrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/ghp_back.sv
// back end: sticky error and text status, output register
module ghp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  ghp_pkg::ghp_item_t item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic [2:0]         out_class,
  output logic               out_last,
  output logic               out_done,
  output logic [1:0]         out_error,
  output logic               out_text
);

  logic [1:0] err_latch, err_latch_next, err_base;
  logic       text_latch, text_latch_next;

  assign pop = item_valid && (!out_valid || out_ready);

  // first error of a member sticks, start of stream clears
  always_comb begin
    err_base        = item.start ? ghp_pkg::ERR_NONE : err_latch;
    err_latch_next  = (err_base == ghp_pkg::ERR_NONE) ? item.err : err_base;
    text_latch_next = item.text_wr ? item.text_val : (item.start ? 1'b0 : text_latch);
  end

  // status latches
  always_ff @(posedge clk) begin
    if (rst) begin
      err_latch  <= ghp_pkg::ERR_NONE;
      text_latch <= 1'b0;
    end else if (pop) begin
      err_latch  <= err_latch_next;
      text_latch <= text_latch_next;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte  <= item.data;
      out_class <= item.cls;
      out_last  <= item.last;
      out_done  <= item.done;
      out_error <= err_latch_next;
      out_text  <= text_latch_next;
    end
  end

endmodule

### hdl/gzip_header_parser_core.sv
// top level of the gzip member header parser
//
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tdata: data_byte; tuser: start_of_stream
// m_axis    out  tvalid/tready          tdata: byte_out, header_done, error_code,
//                                       text_flag; tuser: byte_class; tlast: field_last
// cfg       in   cfg_we                 cfg_index, cfg_data
//
// one byte per cycle unless m_axis stalls; a beat passes the queue and output register
// the front classifies and updates the byte-wide crc32 in the accepting cycle
// a queue of FifoDepth beats lets the front keep taking bytes while m_axis stalls
// s_axis_tready drops only when that queue is full
// rst is synchronous: phase machine, queue and output valid clear, both checks enable
module gzip_header_parser_core #(
  parameter int FifoDepth = ghp_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] start_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] byte_out, [8] header_done,
                                      // [10:9] error_code, [11] text_flag, [15:12] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] byte_class
  output logic        m_axis_tlast,   // field_last
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data
);

  logic               hcrc_en;
  logic               method_en;
  logic               push, pop, full, empty;
  ghp_pkg::ghp_item_t front_item, back_item;
  logic [ghp_pkg::ITEM_W-1:0] rd_bits;
  logic [7:0]         out_byte;
  logic               out_done, out_text;
  logic [1:0]         out_error;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hcrc_en   <= 1'b1;
      method_en <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        ghp_pkg::CFG_HCRC_EN:   hcrc_en   <= cfg_data;
        ghp_pkg::CFG_METHOD_EN: method_en <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ghp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_start  (s_axis_tuser),
    .hcrc_en   (hcrc_en),
    .method_en (method_en),
    .full      (full),
    .push      (push),
    .item      (front_item)
  );

  ghp_fifo #(
    .Depth (FifoDepth),
    .Width (ghp_pkg::ITEM_W)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (front_item),
    .rd_en   (pop),
    .rd_data (rd_bits),
    .full    (full),
    .empty   (empty)
  );

  assign back_item = rd_bits;

  ghp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (!empty),
    .item       (back_item),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (out_byte),
    .out_class  (m_axis_tuser),
    .out_last   (m_axis_tlast),
    .out_done   (out_done),
    .out_error  (out_error),
    .out_text   (out_text)
  );

  assign m_axis_tdata = {4'h0, out_text, out_error, out_done, out_byte};

  // a byte after an error always carries a nonzero error code
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ghp_pkg::PH_ERROR
      |-> m_axis_tdata[10:9] != ghp_pkg::ERR_NONE)
    else $error("error-class beat without error code");

  // end of header is always the end of a field
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tlast)
    else $error("header_done without field_last");

  // payload and error bytes never end a field
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ghp_pkg::PH_PAYLOAD || m_axis_tuser == ghp_pkg::PH_ERROR)
      |-> !m_axis_tlast)
    else $error("field_last outside the header");

endmodule
